@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on the rising clock, off during reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

@@ hdl/coap_pkg.sv @@
// Types, codes and constants of the CoAP message parser.
// No dependencies; used by all parser modules.
package coap_pkg;

  localparam int unsigned OutqDepth = 4;
  localparam int unsigned OutqAw    = $clog2(OutqDepth);
  localparam int unsigned OutqCw    = $clog2(OutqDepth + 1);

  localparam logic [3:0] MaxTokenLen = 4'd8;
  localparam logic [3:0] NibExt1     = 4'd13;
  localparam logic [3:0] NibExt2     = 4'd14;
  localparam logic [3:0] NibBad      = 4'd15;
  localparam logic [7:0] PayloadMark = 8'hFF;
  localparam logic [1:0] CoapVersion = 2'd1;
  localparam logic [16:0] Ext1Bias   = 17'd13;
  localparam logic [16:0] Ext2Bias   = 17'd269;

  typedef enum logic [1:0] {
    REC_HEADER  = 2'd0,
    REC_OPTION  = 2'd1,
    REC_PAYLOAD = 2'd2,
    REC_END     = 2'd3
  } coap_kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_BAD_VER   = 3'd2,
    ST_BAD_TKL   = 3'd3,
    ST_BAD_DELTA = 3'd4,
    ST_BAD_LEN   = 3'd5,
    ST_OVERSIZE  = 3'd6
  } coap_status_e;

  typedef enum logic [3:0] {
    PH_HDR     = 4'd0,
    PH_TOKEN   = 4'd1,
    PH_OPT     = 4'd2,
    PH_DEXT1   = 4'd3,
    PH_DEXT2   = 4'd4,
    PH_LEXT1   = 4'd5,
    PH_LEXT2   = 4'd6,
    PH_VALUE   = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_SKIP    = 4'd9
  } coap_phase_e;

  typedef struct packed {
    coap_kind_e   record_kind;
    coap_status_e status;
    logic [1:0]   message_type;
    logic [3:0]   token_length;
    logic [7:0]   message_code;
    logic [15:0]  message_id;
    logic [31:0]  option_number;
    logic [16:0]  option_length;
    logic [15:0]  byte_offset;
    logic [15:0]  payload_length;
    logic         last_result;
  } coap_rec_t;

  // Records produced by one byte: zero, one or two, first in rec_a.
  typedef struct packed {
    logic [1:0] num;
    coap_rec_t  rec_a;
    coap_rec_t  rec_b;
  } coap_push_t;

endpackage

@@ hdl/coap_if.sv @@
// Valid/ready channels of the CoAP message parser: byte input and record output.
// No dependencies.
interface coap_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface coap_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [2:0]  status;
  logic [1:0]  message_type;
  logic [3:0]  token_length;
  logic [7:0]  message_code;
  logic [15:0] message_id;
  logic [31:0] option_number;
  logic [16:0] option_length;
  logic [15:0] byte_offset;
  logic [15:0] payload_length;
  logic        last_result;

  modport source (
    output valid, output record_kind, output status, output message_type,
    output token_length, output message_code, output message_id,
    output option_number, output option_length, output byte_offset,
    output payload_length, output last_result, input ready
  );
  modport sink (
    input valid, input record_kind, input status, input message_type,
    input token_length, input message_code, input message_id,
    input option_number, input option_length, input byte_offset,
    input payload_length, input last_result, output ready
  );
endinterface

@@ hdl/coap_parse.sv @@
// Per-byte parse step: packet state registers and the decode of one byte.
// Depends on coap_pkg.
module coap_byte_step
  import coap_pkg::*;
#(
  parameter logic [3:0] TokenLenMax = MaxTokenLen
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output coap_push_t push_o
);

  coap_phase_e  phase_q, phase_d;
  coap_status_e err_q, err_d, end_st;
  logic [15:0]  pos_q, pos_d, pos_p1, off;
  logic [3:0]   tok_q, tok_d, dnib_q, dnib_d, lnib_q, lnib_d;
  logic [23:0]  hdr_q, hdr_d;
  logic [31:0]  sum_q, sum_d;
  logic [16:0]  ext_q, ext_d, vrem_q, vrem_d, vlen_q, vlen_d, cnt;
  logic [15:0]  pst_q, pst_d;
  logic         do_delta, do_len, do_emit, rec_vld;
  coap_rec_t    rec, end_rec;

  always_comb begin
    phase_d  = phase_q;
    err_d    = err_q;
    pos_d    = pos_q;
    tok_d    = tok_q;
    hdr_d    = hdr_q;
    sum_d    = sum_q;
    dnib_d   = dnib_q;
    lnib_d   = lnib_q;
    ext_d    = ext_q;
    vrem_d   = vrem_q;
    vlen_d   = vlen_q;
    pst_d    = pst_q;
    do_delta = 1'b0;
    do_len   = 1'b0;
    do_emit  = 1'b0;
    off      = '0;
    rec_vld  = 1'b0;
    rec      = '0;
    end_rec  = '0;
    end_st   = ST_OK;
    pos_p1   = pos_q + 16'd1;
    cnt      = {1'b0, pos_q} + 17'd1;

    // Saturated byte count: the byte itself is not parsed
    if (pos_q == 16'hFFFF) begin
      if (err_d == ST_OK) err_d = ST_OVERSIZE;
      phase_d = PH_SKIP;
    end else begin
      pos_d = pos_p1;
    end

    case (phase_d)
      PH_HDR: begin
        if (pos_q == 16'd0) begin
          hdr_d[7:0] = data_byte_i;
        end else if (pos_q == 16'd1) begin
          hdr_d[15:8] = data_byte_i;
        end else if (pos_q == 16'd2) begin
          hdr_d[23:16] = data_byte_i;
        end else if (hdr_q[7:6] != CoapVersion) begin
          if (err_d == ST_OK) err_d = ST_BAD_VER;
          phase_d = PH_SKIP;
        end else if (hdr_q[3:0] > TokenLenMax) begin
          if (err_d == ST_OK) err_d = ST_BAD_TKL;
          phase_d = PH_SKIP;
        end else begin
          rec_vld          = 1'b1;
          rec.record_kind  = REC_HEADER;
          rec.message_type = hdr_q[5:4];
          rec.token_length = hdr_q[3:0];
          rec.message_code = hdr_q[15:8];
          rec.message_id   = {hdr_q[23:16], data_byte_i};
          tok_d            = hdr_q[3:0];
          phase_d          = (hdr_q[3:0] != 4'd0) ? PH_TOKEN : PH_OPT;
        end
      end
      PH_TOKEN: begin
        tok_d = tok_q - 4'd1;
        if (tok_d == 4'd0) phase_d = PH_OPT;
      end
      PH_OPT: begin
        if (data_byte_i == PayloadMark) begin
          phase_d = PH_PAYLOAD;
          pst_d   = pos_p1;
          if (!last_byte_i) begin
            rec_vld         = 1'b1;
            rec.record_kind = REC_PAYLOAD;
            rec.byte_offset = pos_p1;
          end
        end else begin
          dnib_d = data_byte_i[7:4];
          lnib_d = data_byte_i[3:0];
          if (dnib_d == NibBad) begin
            if (err_d == ST_OK) err_d = ST_BAD_DELTA;
            phase_d = PH_SKIP;
          end else if (dnib_d >= NibExt1) begin
            phase_d = PH_DEXT1;
          end else begin
            ext_d    = {13'd0, dnib_d};
            do_delta = 1'b1;
          end
        end
      end
      PH_DEXT1: begin
        if (dnib_q == NibExt1) begin
          ext_d    = {9'd0, data_byte_i} + Ext1Bias;
          do_delta = 1'b1;
        end else begin
          ext_d   = {1'b0, data_byte_i, 8'd0};
          phase_d = PH_DEXT2;
        end
      end
      PH_DEXT2: begin
        ext_d    = {1'b0, ext_q[15:8], data_byte_i} + Ext2Bias;
        do_delta = 1'b1;
      end
      PH_LEXT1: begin
        if (lnib_q == NibExt1) begin
          vrem_d = {9'd0, data_byte_i} + Ext1Bias;
          do_len = 1'b1;
        end else begin
          vrem_d  = {1'b0, data_byte_i, 8'd0};
          phase_d = PH_LEXT2;
        end
      end
      PH_LEXT2: begin
        vrem_d = {1'b0, vrem_q[15:8], data_byte_i} + Ext2Bias;
        do_len = 1'b1;
      end
      PH_VALUE: begin
        vrem_d = vrem_q - 17'd1;
        if (vrem_d == 17'd0) begin
          do_emit = 1'b1;
          off     = pos_p1 - vlen_q[15:0];
        end
      end
      default: begin
      end
    endcase

    // Delta finished: now the length nibble
    if (do_delta) begin
      if (lnib_d == NibBad) begin
        if (err_d == ST_OK) err_d = ST_BAD_LEN;
        phase_d = PH_SKIP;
      end else if (lnib_d >= NibExt1) begin
        phase_d = PH_LEXT1;
      end else begin
        vrem_d = {13'd0, lnib_d};
        do_len = 1'b1;
      end
    end

    if (do_len) begin
      vlen_d = vrem_d;
      if (vrem_d == 17'd0) begin
        do_emit = 1'b1;
        off     = pos_p1;
      end else begin
        phase_d = PH_VALUE;
      end
    end

    if (do_emit) begin
      sum_d             = sum_q + {15'd0, ext_d};
      rec_vld           = 1'b1;
      rec.record_kind   = REC_OPTION;
      rec.option_number = sum_d;
      rec.option_length = vlen_d;
      rec.byte_offset   = off;
      phase_d           = PH_OPT;
    end

    if (last_byte_i) begin
      end_st = err_d;
      if (end_st == ST_OK) begin
        if (phase_d == PH_OPT) begin
          end_st = ST_OK;
        end else if (phase_d == PH_PAYLOAD && cnt > {1'b0, pst_d}) begin
          end_st = ST_OK;
        end else begin
          end_st = ST_TRUNCATED;
        end
      end
      end_rec.record_kind = REC_END;
      end_rec.status      = end_st;
      end_rec.last_result = 1'b1;
      if (end_st == ST_OK && phase_d == PH_PAYLOAD) begin
        end_rec.payload_length = cnt[15:0] - pst_d;
      end
      // Next byte opens a new datagram
      phase_d = PH_HDR;
      err_d   = ST_OK;
      pos_d   = '0;
      tok_d   = '0;
      hdr_d   = '0;
      sum_d   = '0;
      dnib_d  = '0;
      lnib_d  = '0;
      ext_d   = '0;
      vrem_d  = '0;
      vlen_d  = '0;
      pst_d   = '0;
    end

    push_o = '0;
    if (step_i) begin
      if (rec_vld && last_byte_i) begin
        push_o.num   = 2'd2;
        push_o.rec_a = rec;
        push_o.rec_b = end_rec;
      end else if (rec_vld) begin
        push_o.num               = 2'd1;
        push_o.rec_a             = rec;
        push_o.rec_a.last_result = 1'b1;
      end else if (last_byte_i) begin
        push_o.num   = 2'd1;
        push_o.rec_a = end_rec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      err_q   <= ST_OK;
      pos_q   <= '0;
      tok_q   <= '0;
      hdr_q   <= '0;
      sum_q   <= '0;
      dnib_q  <= '0;
      lnib_q  <= '0;
      ext_q   <= '0;
      vrem_q  <= '0;
      vlen_q  <= '0;
      pst_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      err_q   <= err_d;
      pos_q   <= pos_d;
      tok_q   <= tok_d;
      hdr_q   <= hdr_d;
      sum_q   <= sum_d;
      dnib_q  <= dnib_d;
      lnib_q  <= lnib_d;
      ext_q   <= ext_d;
      vrem_q  <= vrem_d;
      vlen_q  <= vlen_d;
      pst_q   <= pst_d;
    end
  end

endmodule

@@ hdl/coap_outq.sv @@
// Result queue: takes up to two records a cycle, hands out one.
// Depends on coap_pkg.
module coap_outq
  import coap_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  coap_push_t push_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output coap_rec_t  rec_o
);

  coap_rec_t         mem_q [OutqDepth];
  logic [OutqAw-1:0] wr_q, wr_d, rd_q, rd_d, wr_p1;
  logic [OutqCw-1:0] cnt_q, cnt_d;
  logic              pop;

  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  // Room for a worst-case byte, ignoring this cycle's pop
  assign room_o  = (cnt_q <= OutqCw'(OutqDepth - 2));
  assign wr_p1   = wr_q + OutqAw'(1);

  always_comb begin
    wr_d  = wr_q + OutqAw'(push_i.num);
    rd_d  = pop ? rd_q + OutqAw'(1) : rd_q;
    cnt_d = cnt_q + OutqCw'(push_i.num) - OutqCw'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q] <= push_i.rec_a;
    if (push_i.num == 2'd2) mem_q[wr_p1] <= push_i.rec_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ hdl/coap_message_parser.sv @@
// CoAP message parser top level: input register, parse step, result queue.
// Depends on coap_pkg, coap_if, coap_byte_step, coap_outq and assert_macros.svh.
//
//   port      direction  carries
//   in_ch_i   sink       data_byte, last_byte: one datagram byte per item
//   rec_ch_o  source     header, option, payload-start and end records
//
// One byte per cycle sustained; a taken byte is parsed from the input register, and
// its records are offered once they are registered in the result queue.
// A byte yields at most two records; the four-entry result queue needs two free
// slots before the parse step fires, so the rate drops only while rec_ch_o stalls.
// Reset returns the parser to the first header byte and empties the queue.
`include "assert_macros.svh"
module coap_message_parser
  import coap_pkg::*;
#(
  parameter logic [3:0] TokenLenMax = MaxTokenLen
) (
  input  logic clk_i,
  input  logic rst_ni,
  coap_byte_if.sink  in_ch_i,
  coap_rec_if.source rec_ch_o
);

  logic       in_vld_q, in_last_q, in_rdy, room, fire;
  logic [7:0] in_byte_q;
  coap_push_t push;
  coap_rec_t  head;
  logic       pushed, out_vld, out_end, out_bad_st;

  assign fire          = in_vld_q && room;
  assign in_rdy        = !in_vld_q || room;
  assign in_ch_i.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.valid && in_rdy) begin
      in_byte_q <= in_ch_i.data_byte;
      in_last_q <= in_ch_i.last_byte;
    end
  end

  coap_byte_step #(
    .TokenLenMax (TokenLenMax)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (fire),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .push_o      (push)
  );

  coap_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (rec_ch_o.valid),
    .ready_i (rec_ch_o.ready),
    .rec_o   (head)
  );

  assign rec_ch_o.record_kind    = head.record_kind;
  assign rec_ch_o.status         = head.status;
  assign rec_ch_o.message_type   = head.message_type;
  assign rec_ch_o.token_length   = head.token_length;
  assign rec_ch_o.message_code   = head.message_code;
  assign rec_ch_o.message_id     = head.message_id;
  assign rec_ch_o.option_number  = head.option_number;
  assign rec_ch_o.option_length  = head.option_length;
  assign rec_ch_o.byte_offset    = head.byte_offset;
  assign rec_ch_o.payload_length = head.payload_length;
  assign rec_ch_o.last_result    = head.last_result;

  assign pushed     = (push.num != 2'd0);
  assign out_vld    = rec_ch_o.valid;
  assign out_end    = out_vld && (rec_ch_o.record_kind == REC_END);
  assign out_bad_st = out_vld && (rec_ch_o.record_kind != REC_END) && (rec_ch_o.status != ST_OK);

  `ASSERT_PROP(a_push_only_on_step, clk_i, rst_ni, pushed |-> fire, "records without a byte")
  `ASSERT_PROP(a_push_shows_valid, clk_i, rst_ni, pushed |=> out_vld, "pushed record not visible")
  `ASSERT_PROP(a_end_is_last, clk_i, rst_ni, out_end |-> rec_ch_o.last_result, "end record not last")
  `ASSERT_NEVER(a_status_only_end, clk_i, rst_ni, out_bad_st, "status outside end record")

endmodule

@@ bench/coap_message_parser_test.sv @@
// Self-checking bench for coap_message_parser: byte items in, parse records out.
// Depends on coap_pkg, coap_if and the parser RTL; records are predicted on the side.
module coap_message_parser_test;
  import coap_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned HoldAt       = 60;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 20;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned gap;
    bit          drain;
  } byte_item_t;

  logic clk_i;
  logic rst_ni;

  coap_byte_if in_ch ();
  coap_rec_if  rec_ch ();

  coap_message_parser u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .rec_ch_o (rec_ch)
  );

  // pending bytes, packet under construction, predicted records
  byte_item_t  tx_bytes[$];
  logic [7:0]  pkt[$];
  coap_rec_t   want_recs[$];
  coap_rec_t   step_recs[$];
  coap_rec_t   want_rec;

  int unsigned fails;
  int unsigned recs_seen;
  int unsigned idle_cycles;
  logic        in_taken;
  logic        rec_taken;

  // parser shadow state
  coap_phase_e  prs_phase;
  int unsigned  byte_pos;
  logic [3:0]   tok_left;
  logic [7:0]   hdr_first;
  logic [7:0]   hdr_code;
  logic [7:0]   hdr_id_hi;
  logic [31:0]  opt_sum;
  logic [3:0]   dnib;
  logic [3:0]   lnib;
  int unsigned  ext_val;
  int unsigned  val_rem;
  int unsigned  val_len;
  int unsigned  pay_start;
  coap_status_e err;

  // driver and receiver state
  bit          drv_on;
  bit          gap_armed;
  int unsigned gap_left;
  byte_item_t  nxt;
  bit          rcv_started;
  bit          rcv_calm;
  bit          hold_done;
  int unsigned rcv_wait;

  task automatic clear_parser();
    prs_phase = PH_HDR;
    byte_pos  = 0;
    tok_left  = '0;
    hdr_first = '0;
    hdr_code  = '0;
    hdr_id_hi = '0;
    opt_sum   = '0;
    dnib      = '0;
    lnib      = '0;
    ext_val   = 0;
    val_rem   = 0;
    val_len   = 0;
    pay_start = 0;
    err       = ST_OK;
  endtask

  task automatic flag_error(input coap_status_e code);
    if (err == ST_OK) err = code;
    prs_phase = PH_SKIP;
  endtask

  task automatic emit_option(input int unsigned offset);
    coap_rec_t r;
    opt_sum         = opt_sum + ext_val;
    r               = '0;
    r.record_kind   = REC_OPTION;
    r.option_number = opt_sum;
    r.option_length = 17'(val_len);
    r.byte_offset   = 16'(offset);
    step_recs.push_back(r);
    prs_phase = PH_OPT;
  endtask

  task automatic length_done(input int unsigned pos);
    val_len = val_rem;
    if (val_rem == 0) emit_option(pos + 1);
    else prs_phase = PH_VALUE;
  endtask

  task automatic delta_done(input int unsigned pos);
    if (lnib == NibBad) begin
      flag_error(ST_BAD_LEN);
    end else if (lnib >= NibExt1) begin
      prs_phase = PH_LEXT1;
    end else begin
      val_rem = 32'(lnib);
      length_done(pos);
    end
  endtask

  // Works out the records one accepted byte causes and queues them.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    int unsigned  pos;
    int unsigned  count;
    coap_status_e st;
    coap_rec_t    r;
    pos = byte_pos;
    step_recs.delete();
    if (pos >= 32'hFFFF) flag_error(ST_OVERSIZE);
    else byte_pos = pos + 1;

    case (prs_phase)
      PH_HDR: begin
        if (pos == 0) hdr_first = b;
        else if (pos == 1) hdr_code = b;
        else if (pos == 2) hdr_id_hi = b;
        else if (hdr_first[7:6] != CoapVersion) flag_error(ST_BAD_VER);
        else if (hdr_first[3:0] > MaxTokenLen) flag_error(ST_BAD_TKL);
        else begin
          r              = '0;
          r.record_kind  = REC_HEADER;
          r.message_type = hdr_first[5:4];
          r.token_length = hdr_first[3:0];
          r.message_code = hdr_code;
          r.message_id   = {hdr_id_hi, b};
          step_recs.push_back(r);
          tok_left  = hdr_first[3:0];
          prs_phase = (tok_left != 0) ? PH_TOKEN : PH_OPT;
        end
      end
      PH_TOKEN: begin
        tok_left = tok_left - 4'd1;
        if (tok_left == 0) prs_phase = PH_OPT;
      end
      PH_OPT: begin
        if (b == PayloadMark) begin
          prs_phase = PH_PAYLOAD;
          pay_start = pos + 1;
          // marker on the final byte gives no payload-start record
          if (!last) begin
            r             = '0;
            r.record_kind = REC_PAYLOAD;
            r.byte_offset = 16'(pos + 1);
            step_recs.push_back(r);
          end
        end else begin
          dnib = b[7:4];
          lnib = b[3:0];
          if (dnib == NibBad) begin
            flag_error(ST_BAD_DELTA);
          end else if (dnib >= NibExt1) begin
            prs_phase = PH_DEXT1;
          end else begin
            ext_val = 32'(dnib);
            delta_done(pos);
          end
        end
      end
      PH_DEXT1: begin
        if (dnib == NibExt1) begin
          ext_val = 32'(b) + 32'(Ext1Bias);
          delta_done(pos);
        end else begin
          ext_val   = 32'({b, 8'h00});
          prs_phase = PH_DEXT2;
        end
      end
      PH_DEXT2: begin
        ext_val = (ext_val | 32'(b)) + 32'(Ext2Bias);
        delta_done(pos);
      end
      PH_LEXT1: begin
        if (lnib == NibExt1) begin
          val_rem = 32'(b) + 32'(Ext1Bias);
          length_done(pos);
        end else begin
          val_rem   = 32'({b, 8'h00});
          prs_phase = PH_LEXT2;
        end
      end
      PH_LEXT2: begin
        val_rem = (val_rem | 32'(b)) + 32'(Ext2Bias);
        length_done(pos);
      end
      PH_VALUE: begin
        val_rem = val_rem - 1;
        if (val_rem == 0) emit_option(pos + 1 - val_len);
      end
      default: ;
    endcase

    if (last) begin
      count = pos + 1;
      st    = err;
      if (st == ST_OK && !(prs_phase == PH_OPT ||
                           (prs_phase == PH_PAYLOAD && count > pay_start)))
        st = ST_TRUNCATED;
      r             = '0;
      r.record_kind = REC_END;
      r.status      = st;
      if (st == ST_OK && prs_phase == PH_PAYLOAD) r.payload_length = 16'(count - pay_start);
      step_recs.push_back(r);
      clear_parser();
    end

    if (step_recs.size() != 0) begin
      r = step_recs.pop_back();
      r.last_result = 1'b1;
      step_recs.push_back(r);
    end
    foreach (step_recs[i]) want_recs.push_back(step_recs[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  // Well-formed message with random header, token, options and payload.
  task automatic build_wellformed();
    logic [3:0]  tkl;
    logic [3:0]  dn;
    logic [3:0]  ln;
    logic [7:0]  dext[$];
    logic [7:0]  lext[$];
    int unsigned vlen;
    int unsigned sel;
    int unsigned e;
    tkl = 4'($urandom_range(0, MaxTokenLen));
    pkt.push_back({CoapVersion, 2'($urandom_range(0, 3)), tkl});
    repeat (3 + tkl) pkt.push_back(8'($urandom));
    repeat ($urandom_range(0, 5)) begin
      dext.delete();
      lext.delete();
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        dn = 4'($urandom_range(0, 12));
      end else if (sel < 8) begin
        dn = NibExt1;
        dext.push_back(8'($urandom));
      end else begin
        dn = NibExt2;
        dext.push_back(8'($urandom));
        dext.push_back(8'($urandom));
      end
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
        ln   = 4'($urandom_range(0, 12));
        vlen = 32'(ln);
      end else if (sel < 19) begin
        ln   = NibExt1;
        e    = $urandom_range(0, 20);
        vlen = e + 13;
        lext.push_back(8'(e));
      end else begin
        ln   = NibExt2;
        e    = $urandom_range(0, 20);
        vlen = e + 269;
        lext.push_back(8'h00);
        lext.push_back(8'(e));
      end
      pkt.push_back({dn, ln});
      foreach (dext[i]) pkt.push_back(dext[i]);
      foreach (lext[i]) pkt.push_back(lext[i]);
      repeat (vlen) pkt.push_back(8'($urandom));
    end
    if ($urandom_range(0, 2) != 0) begin
      pkt.push_back(PayloadMark);
      repeat ($urandom_range(1, 16)) pkt.push_back(8'($urandom));
    end
  endtask

  // Moves the packet into the send queue; last flag on its final byte.
  task automatic send_packet(input bit calm, input bit drain);
    byte_item_t it;
    foreach (pkt[i]) begin
      it.data  = pkt[i];
      it.last  = (i == pkt.size() - 1);
      it.gap   = calm ? 0 : $urandom_range(0, 15);
      it.drain = drain && (i == 0);
      tx_bytes.push_back(it);
    end
    pkt.delete();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // byte driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      drv_on    = 1'b0;
      gap_armed = 1'b0;
      gap_left  = 0;
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= '0;
      in_ch.last_byte <= 1'b0;
    end else begin
      if (drv_on && in_taken) drv_on = 1'b0;
      if (!drv_on && tx_bytes.size() != 0) begin
        if (!gap_armed) begin
          gap_left  = tx_bytes[0].gap;
          gap_armed = 1'b1;
        end
        // a drain item waits until every queued record has come out
        if (!(tx_bytes[0].drain && want_recs.size() != 0)) begin
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            nxt       = tx_bytes.pop_front();
            drv_on    = 1'b1;
            gap_armed = 1'b0;
            in_ch.data_byte <= nxt.data;
            in_ch.last_byte <= nxt.last;
          end
        end
      end
      in_ch.valid <= drv_on;
    end
  end

  // record receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rcv_started = 1'b0;
      rcv_calm    = 1'b0;
      hold_done   = 1'b0;
      rcv_wait    = 0;
      rec_ch.ready <= 1'b0;
    end else begin
      if (rec_taken || !rcv_started) begin
        rcv_started = 1'b1;
        if (recs_seen == HoldAt && !hold_done) begin
          rcv_wait  = HoldCycles;
          hold_done = 1'b1;
        end else begin
          rcv_wait = rcv_calm ? 0 : $urandom_range(0, 15);
        end
        if ($urandom_range(0, 31) == 0) rcv_calm = !rcv_calm;
      end
      if (rcv_wait != 0) begin
        rcv_wait--;
        rec_ch.ready <= 1'b0;
      end else begin
        rec_ch.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted bytes, compare accepted records
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken  <= 1'b0;
      rec_taken <= 1'b0;
      fails     = 0;
      recs_seen = 0;
      clear_parser();
    end else begin
      in_taken  <= in_ch.valid && in_ch.ready;
      rec_taken <= rec_ch.valid && rec_ch.ready;
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.data_byte, in_ch.last_byte);
      if (rec_ch.valid && rec_ch.ready) begin
        recs_seen++;
        if (want_recs.size() == 0) begin
          $error("record with none expected, kind %0d", rec_ch.record_kind);
          fails++;
        end else begin
          want_rec = want_recs.pop_front();
          check_field("record_kind", want_rec.record_kind, rec_ch.record_kind);
          check_field("status", want_rec.status, rec_ch.status);
          check_field("message_type", want_rec.message_type, rec_ch.message_type);
          check_field("token_length", want_rec.token_length, rec_ch.token_length);
          check_field("message_code", want_rec.message_code, rec_ch.message_code);
          check_field("message_id", want_rec.message_id, rec_ch.message_id);
          check_field("option_number", want_rec.option_number, rec_ch.option_number);
          check_field("option_length", want_rec.option_length, rec_ch.option_length);
          check_field("byte_offset", want_rec.byte_offset, rec_ch.byte_offset);
          check_field("payload_length", want_rec.payload_length, rec_ch.payload_length);
          check_field("last_result", want_rec.last_result, rec_ch.last_result);
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (rec_ch.valid && rec_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned base_n;
    int unsigned cut;
    int unsigned kind;
    bit          calm;
    bit          first;
    rst_ni = 1'b0;

    // directed
    pkt = '{8'h40};                     // header cut short
    send_packet(0, 0);
    pkt = '{8'h89, 8'h00, 8'h00, 8'h00}; // bad version wins over token length
    send_packet(0, 0);
    pkt = '{8'h49, 8'h00, 8'h00, 8'h00, 8'h11}; // bad token length, rest ignored
    send_packet(0, 0);
    pkt = '{8'h78, 8'hFF, 8'hFF, 8'hFF}; // extremes, token cut off
    send_packet(1, 0);
    pkt = '{8'h51, 8'h45, 8'h12, 8'h34, 8'hAA, 8'hD1, 8'h00, 8'h55,
            8'hE0, 8'h00, 8'h01, PayloadMark, 8'h01};
    send_packet(0, 0);
    pkt = '{8'h40, 8'h00, 8'h00, 8'h00, 8'hF0}; // bad delta on final byte
    send_packet(0, 0);
    pkt = '{8'h40, 8'h00, 8'h00, 8'h00, 8'hDF, 8'h05}; // bad length after extension
    send_packet(1, 0);
    pkt = '{8'h60, 8'h00, 8'h00, 8'h00, PayloadMark}; // marker on final byte
    send_packet(0, 0);
    pkt = '{8'h40, 8'h00, 8'h00, 8'h00, 8'h0E, 8'h01, 8'h00, 8'hAB}; // value cut off
    send_packet(0, 0);
    pkt = '{8'h40, 8'h01, 8'h00, 8'h00, 8'h00}; // empty option on final byte
    send_packet(1, 0);

    // random: mostly well-formed messages, some cut, corrupted or pure noise
    base_n = tx_bytes.size();
    first  = 1'b1;
    while (tx_bytes.size() - base_n < 520) begin
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
      end else begin
        build_wellformed();
        if (kind == 7) begin
          cut = $urandom_range(1, pkt.size());
          pkt = pkt[0:cut-1];
        end else if (kind == 8) begin
          pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
        end
      end
      send_packet(calm, first);
      first = 1'b0;
    end

    build_wellformed();
    send_packet(0, 1);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (tx_bytes.size() != 0 || drv_on || want_recs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
